FILE: rtl/owfk_pkg.sv
// Shared types and constants for the omni wheel field kinematics block.
// Holds the CORDIC angle table, datapath widths and the cell hand-off struct.
// No dependencies.
package owfk_pkg;

    localparam int CORDIC_ITERS = 30;
    localparam int XW = 34;   // CORDIC x/y width, Q2.30 plus headroom
    localparam int ZW = 34;   // CORDIC residual angle, 32-bit turn plus headroom
    localparam int CW = 40;   // rotated speed in Q.16
    localparam int WW = 49;   // spin term in Q.16
    localparam int SW = 52;   // wheel sum
    localparam int MW = 50;   // wheel sum magnitude
    localparam int HW = 25;   // half of the magnitude for the partial products

    localparam logic signed [XW-1:0] CORDIC_GAIN_Q30 = XW'(652032874);

    localparam logic [31:0] ATAN_TURN [CORDIC_ITERS] = '{
        32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4, 32'h028B0D43,
        32'h0145D7E1, 32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2F,
        32'h000A2F98, 32'h000517CC, 32'h00028BE6, 32'h000145F3, 32'h0000A2FA,
        32'h0000517D, 32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
        32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051, 32'h00000029,
        32'h00000014, 32'h0000000A, 32'h00000005, 32'h00000003, 32'h00000001
    };

    typedef struct packed {
        logic signed [15:0] vx;
        logic signed [15:0] vy;
        logic signed [15:0] spin;
        logic               neg;
    } t_side;

    typedef struct packed {
        logic               valid;
        logic signed [XW-1:0] x;
        logic signed [XW-1:0] y;
        logic signed [ZW-1:0] z;
        t_side              side;
    } t_cord;

endpackage

FILE: rtl/owfk_cordic_cell.sv
// One CORDIC rotation cell: a single micro-rotation of fixed shift IDX.
// Depends on owfk_pkg for the angle table and the hand-off struct.
module owfk_cordic_cell #(
    parameter int IDX = 0
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  owfk_pkg::t_cord  i_cord,
    output owfk_pkg::t_cord  o_cord
);
    import owfk_pkg::*;

    localparam logic signed [ZW-1:0] ATAN = ZW'(ATAN_TURN[IDX]);

    logic signed [XW-1:0] w_dx;
    logic signed [XW-1:0] w_dy;
    t_cord                n_cord;
    t_cord                r_cord;

    always_comb begin
        w_dx   = i_cord.x >>> IDX;
        w_dy   = i_cord.y >>> IDX;
        n_cord = i_cord;
        if (!i_cord.z[ZW-1]) begin
            n_cord.x = i_cord.x - w_dy;
            n_cord.y = i_cord.y + w_dx;
            n_cord.z = i_cord.z - ATAN;
        end else begin
            n_cord.x = i_cord.x + w_dy;
            n_cord.y = i_cord.y - w_dx;
            n_cord.z = i_cord.z + ATAN;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cord.valid <= 1'b0;
        end else begin
            r_cord <= n_cord;
        end
    end

    assign o_cord = r_cord;

endmodule

FILE: rtl/owfk_wheel.sv
// Per-wheel output chain: mix, magnitude, rpm scaling, saturation, speed gain.
// Depends on owfk_pkg for datapath widths. Six register stages.
module owfk_wheel #(
    parameter bit NEG_X = 1'b0,
    parameter bit NEG_Y = 1'b0
) (
    input  logic                            i_clk,
    input  logic signed [owfk_pkg::CW-1:0]  i_cx,
    input  logic signed [owfk_pkg::CW-1:0]  i_cy,
    input  logic signed [owfk_pkg::WW-1:0]  i_w,
    input  logic [31:0]                     i_rpm_ratio,
    input  logic [15:0]                     i_speed_gain,
    output logic signed [15:0]              o_target
);
    import owfk_pkg::*;

    logic signed [SW-1:0] w_tx, w_ty, n_sum;
    logic signed [SW-1:0] r_sum;
    logic                 r_neg1, r_neg2, r_neg3, r_neg4;
    logic [MW-1:0]        r_mag;
    logic [HW+15:0]       r_phh, r_phl, r_plh, r_pll;
    logic [81:0]          w_prod;
    logic [49:0]          w_rpm;
    logic [15:0]          w_cap3, n_rpm, r_rpm;
    logic [31:0]          r_fin;
    logic [23:0]          w_fin;
    logic [15:0]          w_cap5, w_sat;
    logic signed [15:0]   r_target;

    always_comb begin
        w_tx  = NEG_X ? -SW'(i_cx) : SW'(i_cx);
        w_ty  = NEG_Y ? -SW'(i_cy) : SW'(i_cy);
        n_sum = w_tx + w_ty + SW'(i_w);
    end

    // sign travelling with the partial products selects the rpm cap
    always_comb begin
        w_prod = (82'(r_phh) << (2 * 16 + 2 * HW - 16 - HW))
               + (82'(r_phl) << HW)
               + (82'(r_plh) << 16)
               + 82'(r_pll);
        w_rpm  = w_prod[81:32];
        w_cap3 = r_neg2 ? 16'd32768 : 16'd32767;
        n_rpm  = (w_rpm > 50'(w_cap3)) ? w_cap3 : w_rpm[15:0];
    end

    always_comb begin
        w_fin  = r_fin[31:8];
        w_cap5 = r_neg4 ? 16'd32768 : 16'd32767;
        w_sat  = (w_fin > 24'(w_cap5)) ? w_cap5 : w_fin[15:0];
    end

    always_ff @(posedge i_clk) begin
        r_sum    <= n_sum;
        r_neg1   <= r_sum[SW-1];
        r_mag    <= MW'(r_sum[SW-1] ? -r_sum : r_sum);
        r_neg2   <= r_neg1;
        r_phh    <= r_mag[MW-1:HW] * i_rpm_ratio[31:16];
        r_phl    <= r_mag[MW-1:HW] * i_rpm_ratio[15:0];
        r_plh    <= r_mag[HW-1:0] * i_rpm_ratio[31:16];
        r_pll    <= r_mag[HW-1:0] * i_rpm_ratio[15:0];
        r_neg3   <= r_neg2;
        r_rpm    <= n_rpm;
        r_neg4   <= r_neg3;
        r_fin    <= r_rpm * i_speed_gain;
        r_target <= r_neg4 ? -$signed(w_sat) : $signed(w_sat);
    end

    assign o_target = r_target;

endmodule

FILE: rtl/omni_wheel_field_kinematics.sv
// Top level of the field-oriented four-wheel omni inverse kinematics block.
// Depends on owfk_pkg, owfk_cordic_cell and owfk_wheel.
//
//  channel   ports                                   handshake
//  command   i_vx_cmd i_vy_cmd i_spin_cmd i_heading  start high, busy low
//  result    o_wheel0..3_target                      o_strobe, one cycle
//  config    psel penable pwrite paddr pwdata prdata APB, pready tied high
//
// One command enters every cycle; busy never rises. Each result passes through
// the entry register, the 30-cell CORDIC chain, the trig rounding, multiply
// and rotate stages and the six-stage wheel chain before o_strobe marks it.
// The receiver cannot stall: results leave on the strobe beat regardless.
// Synchronous reset clears valid flags and restores register defaults.
module omni_wheel_field_kinematics #(
    parameter int TRIG_BITS  = 15,
    parameter int ANGLE_BITS = 16
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               start,
    output logic               busy,
    input  logic signed [15:0] i_vx_cmd,
    input  logic signed [15:0] i_vy_cmd,
    input  logic signed [15:0] i_spin_cmd,
    input  logic [15:0]        i_heading,
    output logic               o_strobe,
    output logic signed [15:0] o_wheel0_target,
    output logic signed [15:0] o_wheel1_target,
    output logic signed [15:0] o_wheel2_target,
    output logic signed [15:0] o_wheel3_target,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [3:0]         paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready
);
    import owfk_pkg::*;

    localparam logic [1:0] REG_ROTATE_GAIN = 2'd0;
    localparam logic [1:0] REG_SPEED_GAIN  = 2'd1;
    localparam logic [1:0] REG_RPM_RATIO   = 2'd2;
    localparam logic [1:0] REG_ARM_LENGTH  = 2'd3;

    localparam int AE = (ANGLE_BITS < 16) ? ANGLE_BITS : 16;
    localparam logic [15:0] HMASK = ~16'((32'd1 << (16 - AE)) - 32'd1);
    localparam int TW  = TRIG_BITS + 2;
    localparam int PRW = 16 + TW;
    localparam int WL  = 6;
    localparam logic signed [ZW-1:0] QTR  = ZW'(64'sh40000000);
    localparam logic signed [ZW-1:0] HALF = ZW'(64'sh80000000);
    localparam logic signed [XW-1:0] RND  = XW'(1) << (29 - TRIG_BITS);
    localparam logic signed [XW-1:0] LIM  = XW'(1) << TRIG_BITS;

    // configuration registers
    logic [15:0] r_rotate_gain, r_speed_gain, r_arm_length;
    logic [31:0] r_rpm_ratio;
    logic        w_wr;

    assign pready = 1'b1;
    assign busy   = 1'b0;
    assign w_wr   = psel & penable & pwrite & pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rotate_gain <= 16'd128;
            r_speed_gain  <= 16'd384;
            r_rpm_ratio   <= 32'd65536;
            r_arm_length  <= 16'd256;
        end else if (w_wr) begin
            case (paddr[3:2])
                REG_ROTATE_GAIN: r_rotate_gain <= pwdata[15:0];
                REG_SPEED_GAIN:  r_speed_gain  <= pwdata[15:0];
                REG_RPM_RATIO:   r_rpm_ratio   <= pwdata;
                REG_ARM_LENGTH:  r_arm_length  <= pwdata[15:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (paddr[3:2])
            REG_ROTATE_GAIN: prdata = {16'h0, r_rotate_gain};
            REG_SPEED_GAIN:  prdata = {16'h0, r_speed_gain};
            REG_RPM_RATIO:   prdata = r_rpm_ratio;
            REG_ARM_LENGTH:  prdata = {16'h0, r_arm_length};
            default:         prdata = 32'h0;
        endcase
    end

    // entry stage: reduce heading to a half-turn range, flip flag carried along
    logic signed [ZW-1:0] w_z_raw;
    t_cord                n_in, r_in;

    always_comb begin
        w_z_raw        = ZW'($signed({i_heading & HMASK, 16'h0}));
        n_in.valid     = start & ~busy;
        n_in.x         = CORDIC_GAIN_Q30;
        n_in.y         = '0;
        n_in.side.vx   = i_vx_cmd;
        n_in.side.vy   = i_vy_cmd;
        n_in.side.spin = i_spin_cmd;
        if (w_z_raw > QTR) begin
            n_in.z        = w_z_raw - HALF;
            n_in.side.neg = 1'b1;
        end else if (w_z_raw < -QTR) begin
            n_in.z        = w_z_raw + HALF;
            n_in.side.neg = 1'b1;
        end else begin
            n_in.z        = w_z_raw;
            n_in.side.neg = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in.valid <= 1'b0;
        end else begin
            r_in <= n_in;
        end
    end

    // CORDIC chain: one micro-rotation per cell, one cell per cycle
    t_cord w_chain [CORDIC_ITERS+1];
    assign w_chain[0] = r_in;

    for (genvar g = 0; g < CORDIC_ITERS; g++) begin : g_cell
        owfk_cordic_cell #(.IDX(g)) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_cord  (w_chain[g]),
            .o_cord  (w_chain[g+1])
        );
    end

    t_cord w_end;
    assign w_end = w_chain[CORDIC_ITERS];

    // undo the half-turn flip, round half up to Q(TRIG_BITS) and clamp
    logic signed [XW-1:0] w_xf, w_yf, w_xr, w_yr;
    logic signed [TW-1:0] n_c, n_s, r_c, r_s;
    t_side                r_side1;
    logic                 r_vld1, r_vld2, r_vld3;

    always_comb begin
        w_xf = w_end.side.neg ? -w_end.x : w_end.x;
        w_yf = w_end.side.neg ? -w_end.y : w_end.y;
        w_xr = (w_xf + RND) >>> (30 - TRIG_BITS);
        w_yr = (w_yf + RND) >>> (30 - TRIG_BITS);
        if (w_xr > LIM)       n_c = TW'(LIM);
        else if (w_xr < -LIM) n_c = TW'(-LIM);
        else                  n_c = TW'(w_xr);
        if (w_yr > LIM)       n_s = TW'(LIM);
        else if (w_yr < -LIM) n_s = TW'(-LIM);
        else                  n_s = TW'(w_yr);
    end

    // products of the rotation and the spin gain
    logic signed [PRW-1:0] r_pxc, r_pys, r_pxs, r_pyc;
    logic [31:0]           r_ga;
    logic signed [15:0]    r_spin2;
    logic signed [PRW:0]   w_rx, w_ry;
    logic signed [CW-1:0]  n_cx, n_cy, r_cx, r_cy;
    logic signed [WW-1:0]  r_w;

    always_comb begin
        w_rx = (PRW + 1)'(r_pxc) - (PRW + 1)'(r_pys);
        w_ry = (PRW + 1)'(r_pxs) + (PRW + 1)'(r_pyc);
    end

    if (TRIG_BITS > 16) begin : g_round
        localparam logic signed [CW-1:0] QRND = CW'(1) << (TRIG_BITS - 17);
        always_comb begin
            n_cx = (CW'(w_rx) + QRND) >>> (TRIG_BITS - 16);
            n_cy = (CW'(w_ry) + QRND) >>> (TRIG_BITS - 16);
        end
    end else begin : g_widen
        always_comb begin
            n_cx = CW'(w_rx) <<< (16 - TRIG_BITS);
            n_cy = CW'(w_ry) <<< (16 - TRIG_BITS);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld1 <= 1'b0;
            r_vld2 <= 1'b0;
            r_vld3 <= 1'b0;
        end else begin
            r_vld1 <= w_end.valid;
            r_vld2 <= r_vld1;
            r_vld3 <= r_vld2;
        end
    end

    always_ff @(posedge i_clk) begin
        r_c     <= n_c;
        r_s     <= n_s;
        r_side1 <= w_end.side;
        r_pxc   <= r_side1.vx * r_c;
        r_pys   <= r_side1.vy * r_s;
        r_pxs   <= r_side1.vx * r_s;
        r_pyc   <= r_side1.vy * r_c;
        r_ga    <= r_rotate_gain * r_arm_length;
        r_spin2 <= r_side1.spin;
        r_cx    <= n_cx;
        r_cy    <= n_cy;
        r_w     <= WW'(r_spin2) * WW'($signed({1'b0, r_ga}));
    end

    // wheel chains: left, forward, back, right
    owfk_wheel #(.NEG_X(1'b0), .NEG_Y(1'b0)) u_wheel0 (
        .i_clk(i_clk), .i_cx(r_cx), .i_cy(r_cy), .i_w(r_w),
        .i_rpm_ratio(r_rpm_ratio), .i_speed_gain(r_speed_gain),
        .o_target(o_wheel0_target)
    );
    owfk_wheel #(.NEG_X(1'b0), .NEG_Y(1'b1)) u_wheel1 (
        .i_clk(i_clk), .i_cx(r_cx), .i_cy(r_cy), .i_w(r_w),
        .i_rpm_ratio(r_rpm_ratio), .i_speed_gain(r_speed_gain),
        .o_target(o_wheel1_target)
    );
    owfk_wheel #(.NEG_X(1'b1), .NEG_Y(1'b0)) u_wheel2 (
        .i_clk(i_clk), .i_cx(r_cx), .i_cy(r_cy), .i_w(r_w),
        .i_rpm_ratio(r_rpm_ratio), .i_speed_gain(r_speed_gain),
        .o_target(o_wheel2_target)
    );
    owfk_wheel #(.NEG_X(1'b1), .NEG_Y(1'b1)) u_wheel3 (
        .i_clk(i_clk), .i_cx(r_cx), .i_cy(r_cy), .i_w(r_w),
        .i_rpm_ratio(r_rpm_ratio), .i_speed_gain(r_speed_gain),
        .o_target(o_wheel3_target)
    );

    // advance the valid flag alongside the wheel chains
    logic [WL-1:0] r_vld_w;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld_w <= '0;
        end else begin
            r_vld_w <= {r_vld_w[WL-2:0], r_vld3};
        end
    end

    assign o_strobe = r_vld_w[WL-1];

endmodule
